// ===== rtl/ilsm_pkg.sv =====
// shared types and fixed field widths for the line scan maxima block
package ilsm_pkg;

   localparam int unsigned PIXEL_FIELD_BITS = 8;
   localparam int unsigned RESULT_FIELD_BITS = 11;

   // position flags and forwarding hits carried from the address stage to the update stage
   typedef struct packed {
      logic row_last;
      logic col_first;
      logic col_last;
      logic anti_first;
      logic anti_last;
      logic diag_first;
      logic diag_last;
      logic image_last;
      logic fwd_col;
      logic fwd_anti;
      logic fwd_diag;
   } ilsm_flags_type;

endpackage

// ===== rtl/image_line_scan_maxima_top.sv =====
// after the last pixel transfer, the update stage loads the result into the output register
// throughput: one pixel per cycle; the last pixel of an image waits only while the
//   previous result still sits unread in the output register
// line sums live in three synchronous memories (column, anti-diagonal, diagonal) that are
//   read in the address stage and written back in the update stage, one access each per cycle
// reset is synchronous and active high; it clears positions, row total, maxima and valids,
//   memory contents need no clearing since the first pixel of every line ignores the old sum
module image_line_scan_maxima_top #(
   parameter int unsigned SIDE = 8,
   parameter int unsigned PIXEL_BITS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [ilsm_pkg::PIXEL_FIELD_BITS-1:0]  req_pixel,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [ilsm_pkg::RESULT_FIELD_BITS-1:0] rsp_max_row_sum,
   output logic [ilsm_pkg::RESULT_FIELD_BITS-1:0] rsp_max_column_sum,
   output logic [ilsm_pkg::RESULT_FIELD_BITS-1:0] rsp_max_antidiagonal_sum,
   output logic [ilsm_pkg::RESULT_FIELD_BITS-1:0] rsp_max_diagonal_sum
);
   import ilsm_pkg::*;

   // widths that follow from the image side and pixel depth
   localparam int unsigned LINES     = 2 * SIDE - 1;
   localparam int unsigned POS_BITS  = $clog2(SIDE);
   localparam int unsigned LINE_BITS = $clog2(LINES);
   localparam int unsigned SUM_BITS  = $clog2(SIDE * ((1 << PIXEL_BITS) - 1) + 1);
   localparam int unsigned PIX_WIDE  =
      (PIXEL_BITS > PIXEL_FIELD_BITS) ? PIXEL_BITS : PIXEL_FIELD_BITS;
   localparam int unsigned OUT_WIDE  =
      (SUM_BITS > RESULT_FIELD_BITS) ? SUM_BITS : RESULT_FIELD_BITS;
   localparam logic [POS_BITS-1:0]  POS_LAST  = POS_BITS'(SIDE - 1);
   localparam logic [LINE_BITS-1:0] DIAG_BIAS = LINE_BITS'(SIDE - 1);

   // line sum memories
   logic [SUM_BITS-1:0] col_mem  [SIDE];
   logic [SUM_BITS-1:0] anti_mem [LINES];
   logic [SUM_BITS-1:0] diag_mem [LINES];

   // address stage: raster position
   logic [POS_BITS-1:0] row_ff, row_in;
   logic [POS_BITS-1:0] col_ff, col_in;

   // update stage registers
   logic                 s1_valid_ff, s1_valid_in;
   ilsm_flags_type       s1_flags_ff, s1_flags_in;
   logic [SUM_BITS-1:0]  s1_pixel_ff, s1_pixel_in;
   logic [POS_BITS-1:0]  s1_col_addr_ff;
   logic [LINE_BITS-1:0] s1_anti_addr_ff, s1_diag_addr_ff;
   logic [SUM_BITS-1:0]  col_rd_ff, anti_rd_ff, diag_rd_ff;
   logic [SUM_BITS-1:0]  fwd_col_ff, fwd_anti_ff, fwd_diag_ff;

   // running row total and maxima
   logic [SUM_BITS-1:0] row_total_ff, row_total_in;
   logic [SUM_BITS-1:0] best_row_ff, best_row_in;
   logic [SUM_BITS-1:0] best_col_ff, best_col_in;
   logic [SUM_BITS-1:0] best_anti_ff, best_anti_in;
   logic [SUM_BITS-1:0] best_diag_ff, best_diag_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SUM_BITS-1:0]  out_row_ff, out_col_ff, out_anti_ff, out_diag_ff;

   // address stage combinational
   logic                 req_xfer;
   logic [PIX_WIDE-1:0]  pixel_wide;
   logic [LINE_BITS-1:0] anti_addr, diag_addr;
   logic                 at_row_first, at_row_last, at_col_first, at_col_last;

   // update stage combinational
   logic [SUM_BITS-1:0] col_old, anti_old, diag_old;
   logic [SUM_BITS-1:0] col_new, anti_new, diag_new, row_new;
   logic [SUM_BITS-1:0] row_cand, col_cand, anti_cand, diag_cand;
   logic                result_load;

   // result fields, widened before the low bits are taken
   logic [OUT_WIDE-1:0] out_row_wide, out_col_wide, out_anti_wide, out_diag_wide;

   // ---------------- address stage ----------------

   assign at_row_first = (row_ff == '0);
   assign at_row_last  = (row_ff == POS_LAST);
   assign at_col_first = (col_ff == '0);
   assign at_col_last  = (col_ff == POS_LAST);

   // the final pixel holds back while the previous image's result is unread
   assign req_stall = rsp_valid_ff && at_row_last && at_col_last;
   assign req_xfer  = req_valid && !req_stall;

   assign pixel_wide  = PIX_WIDE'(req_pixel);
   assign s1_pixel_in = SUM_BITS'(pixel_wide[PIXEL_BITS-1:0]);

   assign anti_addr = LINE_BITS'(row_ff) + LINE_BITS'(col_ff);
   assign diag_addr = LINE_BITS'(col_ff) + DIAG_BIAS - LINE_BITS'(row_ff);

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (req_xfer) begin
         if (at_col_last) begin
            col_in = '0;
            row_in = at_row_last ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   // first and last pixel of each line family in raster order
   always_comb begin
      s1_flags_in.row_last   = at_col_last;
      s1_flags_in.col_first  = at_row_first;
      s1_flags_in.col_last   = at_row_last;
      s1_flags_in.anti_first = at_row_first || at_col_last;
      s1_flags_in.anti_last  = at_row_last || at_col_first;
      s1_flags_in.diag_first = at_row_first || at_col_first;
      s1_flags_in.diag_last  = at_row_last || at_col_last;
      s1_flags_in.image_last = at_row_last && at_col_last;
      // a write-back in flight to the entry being read
      s1_flags_in.fwd_col    = s1_valid_ff && (s1_col_addr_ff == col_ff);
      s1_flags_in.fwd_anti   = s1_valid_ff && (s1_anti_addr_ff == anti_addr);
      s1_flags_in.fwd_diag   = s1_valid_ff && (s1_diag_addr_ff == diag_addr);
   end

   assign s1_valid_in = req_xfer;

   // ---------------- update stage ----------------

   always_comb begin
      if (s1_flags_ff.col_first) begin
         col_old = '0;
      end else if (s1_flags_ff.fwd_col) begin
         col_old = fwd_col_ff;
      end else begin
         col_old = col_rd_ff;
      end
      if (s1_flags_ff.anti_first) begin
         anti_old = '0;
      end else if (s1_flags_ff.fwd_anti) begin
         anti_old = fwd_anti_ff;
      end else begin
         anti_old = anti_rd_ff;
      end
      if (s1_flags_ff.diag_first) begin
         diag_old = '0;
      end else if (s1_flags_ff.fwd_diag) begin
         diag_old = fwd_diag_ff;
      end else begin
         diag_old = diag_rd_ff;
      end
   end

   assign col_new  = col_old + s1_pixel_ff;
   assign anti_new = anti_old + s1_pixel_ff;
   assign diag_new = diag_old + s1_pixel_ff;
   assign row_new  = row_total_ff + s1_pixel_ff;

   // a line enters its maximum on its last pixel
   assign row_cand  = (s1_flags_ff.row_last && row_new > best_row_ff) ? row_new : best_row_ff;
   assign col_cand  = (s1_flags_ff.col_last && col_new > best_col_ff) ? col_new : best_col_ff;
   assign anti_cand = (s1_flags_ff.anti_last && anti_new > best_anti_ff) ?
                      anti_new : best_anti_ff;
   assign diag_cand = (s1_flags_ff.diag_last && diag_new > best_diag_ff) ?
                      diag_new : best_diag_ff;

   assign result_load = s1_valid_ff && s1_flags_ff.image_last;

   always_comb begin
      row_total_in = row_total_ff;
      best_row_in  = best_row_ff;
      best_col_in  = best_col_ff;
      best_anti_in = best_anti_ff;
      best_diag_in = best_diag_ff;
      if (s1_valid_ff) begin
         row_total_in = s1_flags_ff.row_last ? '0 : row_new;
         if (s1_flags_ff.image_last) begin
            // maxima restart for the next image
            best_row_in  = '0;
            best_col_in  = '0;
            best_anti_in = '0;
            best_diag_in = '0;
         end else begin
            best_row_in  = row_cand;
            best_col_in  = col_cand;
            best_anti_in = anti_cand;
            best_diag_in = diag_cand;
         end
      end
   end

   // output register: loads at the end of an image, empties on a transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------- registers ----------------

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         row_total_ff <= '0;
         best_row_ff  <= '0;
         best_col_ff  <= '0;
         best_anti_ff <= '0;
         best_diag_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         col_ff       <= col_in;
         s1_valid_ff  <= s1_valid_in;
         row_total_ff <= row_total_in;
         best_row_ff  <= best_row_in;
         best_col_ff  <= best_col_in;
         best_anti_ff <= best_anti_in;
         best_diag_ff <= best_diag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // update stage payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_flags_ff     <= s1_flags_in;
         s1_pixel_ff     <= s1_pixel_in;
         s1_col_addr_ff  <= col_ff;
         s1_anti_addr_ff <= anti_addr;
         s1_diag_addr_ff <= diag_addr;
         fwd_col_ff      <= col_new;
         fwd_anti_ff     <= anti_new;
         fwd_diag_ff     <= diag_new;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (result_load) begin
         out_row_ff  <= row_cand;
         out_col_ff  <= col_cand;
         out_anti_ff <= anti_cand;
         out_diag_ff <= diag_cand;
      end
   end

   // memories: read in the address stage, write back from the update stage
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         col_rd_ff  <= col_mem[col_ff];
         anti_rd_ff <= anti_mem[anti_addr];
         diag_rd_ff <= diag_mem[diag_addr];
      end
      if (s1_valid_ff) begin
         col_mem[s1_col_addr_ff]   <= col_new;
         anti_mem[s1_anti_addr_ff] <= anti_new;
         diag_mem[s1_diag_addr_ff] <= diag_new;
      end
   end

   // ---------------- outputs ----------------

   assign out_row_wide  = OUT_WIDE'(out_row_ff);
   assign out_col_wide  = OUT_WIDE'(out_col_ff);
   assign out_anti_wide = OUT_WIDE'(out_anti_ff);
   assign out_diag_wide = OUT_WIDE'(out_diag_ff);

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_max_row_sum          = out_row_wide[RESULT_FIELD_BITS-1:0];
   assign rsp_max_column_sum       = out_col_wide[RESULT_FIELD_BITS-1:0];
   assign rsp_max_antidiagonal_sum = out_anti_wide[RESULT_FIELD_BITS-1:0];
   assign rsp_max_diagonal_sum     = out_diag_wide[RESULT_FIELD_BITS-1:0];

`ifndef SYNTHESIS
   // a new result never lands on one that is still unread
   assert property (@(posedge clock) disable iff (reset)
      result_load |-> !rsp_valid_ff)
      else $error("result register overwritten");

   // maxima are clear right after an image ends
   assert property (@(posedge clock) disable iff (reset)
      result_load |=> (best_row_ff == '0 && best_col_ff == '0 &&
                       best_anti_ff == '0 && best_diag_ff == '0))
      else $error("maxima not cleared after image");

   // raster position stays inside the image
   assert property (@(posedge clock) disable iff (reset)
      (row_ff <= POS_LAST) && (col_ff <= POS_LAST))
      else $error("raster position out of range");

   // a result appears only after the last pixel of an image
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff && s1_flags_ff.image_last))
      else $error("result without image end");
`endif

endmodule
